>>> sv/ipss_pkg.sv
// Package for the IMU and pressure sample scaler: operation codes, payload
// structures, register indexes and the fixed scaling constants.
// No dependencies; every other file of the block refers to it.
package ipss_pkg;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2
   } op_type;

   typedef enum logic {
      CSR_GYRO_GAIN  = 1'b0,
      CSR_ACCEL_GAIN = 1'b1
   } csr_index_type;

   localparam int GAIN_W   = 20;
   localparam int ACCEL_W  = 12;
   localparam int GYRO_W   = 16;

   localparam logic [GAIN_W-1:0] GYRO_GAIN_RESET  = 20'd286720;
   localparam logic [GAIN_W-1:0] ACCEL_GAIN_RESET = 20'd3998;

   // 10 / (4096 * 1.3332239) in Q0.24, rounded to nearest.
   localparam logic [14:0] PRESS_COEF_Q24 = 15'd30723;
   localparam int          PRESS_SHIFT    = 24;

   // Reciprocal of ten in Q19; exact division for every 16-bit operand.
   localparam logic [15:0] TEMP_RECIP = 16'd52429;
   localparam int          TEMP_SHIFT = 19;

   typedef logic signed [ACCEL_W-1:0] accel_type;
   typedef logic        [ACCEL_W-1:0] span_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [23:0]        pressure_raw;
      logic [15:0]        temperature_raw;
      logic signed [15:0] gyro_raw_x;
      logic signed [15:0] gyro_raw_y;
      logic signed [15:0] gyro_raw_z;
      logic signed [15:0] accel_raw_x;
      logic signed [15:0] accel_raw_y;
      logic signed [15:0] accel_raw_z;
      logic signed [11:0] start_x;
      logic signed [11:0] start_y;
      logic signed [11:0] start_z;
   } req_type;

   typedef struct packed {
      logic [14:0]        pressure_tenths;
      logic [12:0]        temperature_tenth;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [11:0] accel_x;
      logic signed [11:0] accel_y;
      logic signed [11:0] accel_z;
      logic [11:0]        peak_to_peak_x;
      logic [11:0]        peak_to_peak_y;
      logic [11:0]        peak_to_peak_z;
      logic               capturing;
   } rsp_type;

   // Control handed from the datapath to the capture tracker.
   typedef struct packed {
      logic   fire;
      op_type op;
   } track_ctrl_type;

endpackage

>>> sv/ipss_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on ipss_pkg for the payload structures.
interface ipss_req_if;
   logic             valid;
   logic             ready;
   ipss_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ipss_rsp_if;
   logic             valid;
   logic             ready;
   ipss_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/ipss_lane.sv
// One scaling lane: registered raw-times-gain product, then truncation toward
// zero and saturation to OUT_W bits. Depends on ipss_pkg for the gain width.
module ipss_lane #(
   parameter int OUT_W = 16   // 2 to 21
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic signed [15:0]                raw,
   input  logic        [ipss_pkg::GAIN_W-1:0] gain,
   output logic signed [OUT_W-1:0]           scaled
);

   localparam int P_W = 16 + ipss_pkg::GAIN_W + 1;
   localparam logic signed [P_W-1:0] SAT_HI = (P_W'(1) <<< (OUT_W - 1)) - P_W'(1);
   localparam logic signed [P_W-1:0] SAT_LO = -(P_W'(1) <<< (OUT_W - 1));
   localparam logic signed [P_W-1:0] BIAS   = P_W'(16'hFFFF);

   logic signed [P_W-1:0] prod_ff;
   logic signed [P_W-1:0] prod_in;
   logic signed [P_W-1:0] quot;

   assign prod_in = P_W'(raw) * $signed({{(P_W-ipss_pkg::GAIN_W){1'b0}}, gain});

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // Adding 2^16-1 before the arithmetic shift rounds negative values toward zero.
   // Both arms are signed so that the shift keeps the sign of the product.
   assign quot = (prod_ff + (prod_ff[P_W-1] ? BIAS : P_W'(0))) >>> 16;

   always_comb begin
      if (quot > SAT_HI) begin
         scaled = SAT_HI[OUT_W-1:0];
      end else if (quot < SAT_LO) begin
         scaled = SAT_LO[OUT_W-1:0];
      end else begin
         scaled = quot[OUT_W-1:0];
      end
   end

endmodule

>>> sv/ipss_track.sv
// Peak capture tracker: per-axis minimum, maximum and span of the scaled
// acceleration, merged from the three accel lanes. Depends on ipss_pkg.
module ipss_track (
   input  logic                      clock,
   input  logic                      reset,
   input  ipss_pkg::track_ctrl_type  ctrl,
   input  ipss_pkg::accel_type       acc[3],
   input  ipss_pkg::accel_type       seed[3],
   output ipss_pkg::span_type        span_next[3],
   output logic                      cap_next
);

   ipss_pkg::accel_type max_ff[3];
   ipss_pkg::accel_type max_in[3];
   ipss_pkg::accel_type min_ff[3];
   ipss_pkg::accel_type min_in[3];
   ipss_pkg::span_type  span_ff[3];
   logic                cap_ff;

   always_comb begin
      cap_next = cap_ff;
      for (int i = 0; i < 3; i++) begin
         max_in[i]    = max_ff[i];
         min_in[i]    = min_ff[i];
         span_next[i] = span_ff[i];
      end
      if (ctrl.fire) begin
         unique case (ctrl.op)
            ipss_pkg::OP_SAMPLE: begin
               if (cap_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     max_in[i]    = (acc[i] > max_ff[i]) ? acc[i] : max_ff[i];
                     min_in[i]    = (acc[i] < min_ff[i]) ? acc[i] : min_ff[i];
                     span_next[i] = ipss_pkg::span_type'(max_in[i] - min_in[i]);
                  end
               end
            end
            ipss_pkg::OP_START: begin
               cap_next = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  max_in[i]    = seed[i];
                  min_in[i]    = seed[i];
                  span_next[i] = '0;
               end
            end
            ipss_pkg::OP_STOP: begin
               cap_next = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            max_ff[i]  <= '0;
            min_ff[i]  <= '0;
            span_ff[i] <= '0;
         end
      end else begin
         cap_ff <= cap_next;
         for (int i = 0; i < 3; i++) begin
            max_ff[i]  <= max_in[i];
            min_ff[i]  <= min_in[i];
            span_ff[i] <= span_next[i];
         end
      end
   end

endmodule

>>> sv/imu_pressure_sample_scaler_p2p_unit.sv
// Top level of the IMU and pressure sample scaler with peak-to-peak capture.
// Depends on ipss_pkg, ipss_if, ipss_lane and ipss_track.

// The block takes one raw sensor word per cycle unless the response side
// stalls, and returns a scaled word for each. The first stage registers all
// products: six axis lanes work side by side (raw reading times the Q16
// gain), next to the pressure product with the Q0.24 coefficient and the
// temperature product with the Q19 reciprocal of ten. The second stage
// truncates and saturates the axis results, lets the tracker merge the three
// accelerometer lanes into the capture state, and loads the output register.
// Each stage has its own valid bit, so a new word is accepted whenever the
// first stage is empty or can move on, even while a finished word waits in
// the output register; without stalls, throughput is one word per cycle. The
// capture state is updated as a word moves into the output register, so the
// spans and the capturing flag of a word reflect that word's operation.
// Gains take effect for the next word; the user must write them through the
// csr port only while the block is idle, which the block does not enforce.
module imu_pressure_sample_scaler_p2p_unit (
   input  logic                          clock,
   input  logic                          reset,
   ipss_req_if.sink                      req_ch,
   ipss_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ipss_pkg::GAIN_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [ipss_pkg::GAIN_W-1:0] gyro_gain_ff;
   logic [ipss_pkg::GAIN_W-1:0] accel_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_gain_ff  <= ipss_pkg::GYRO_GAIN_RESET;
         accel_gain_ff <= ipss_pkg::ACCEL_GAIN_RESET;
      end else if (csr_we) begin
         unique case (ipss_pkg::csr_index_type'(csr_index))
            ipss_pkg::CSR_GYRO_GAIN:  gyro_gain_ff  <= csr_wdata;
            ipss_pkg::CSR_ACCEL_GAIN: accel_gain_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control: each stage moves when the one after it has room.
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic adv2;
   logic adv1;
   logic load1;
   logic fire;

   assign adv2   = !rsp_valid_ff || rsp_ch.ready;
   assign adv1   = !s1_valid_ff || adv2;
   assign load1  = req_ch.valid && adv1;
   assign fire   = s1_valid_ff && adv2;

   assign req_ch.ready = adv1;
   assign rsp_ch.valid = rsp_valid_ff;

   assign s1_valid_in  = adv1 ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = adv2 ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // First stage: operation, seeds and the pressure and temperature products.
   ipss_pkg::op_type    op_ff;
   ipss_pkg::accel_type seed_ff[3];
   logic [38:0]         press_prod_ff;
   logic [38:0]         press_prod_in;
   logic [31:0]         temp_prod_ff;
   logic [31:0]         temp_prod_in;

   assign press_prod_in = 39'(req_ch.payload.pressure_raw) * 39'(ipss_pkg::PRESS_COEF_Q24);
   assign temp_prod_in  = 32'(req_ch.payload.temperature_raw) * 32'(ipss_pkg::TEMP_RECIP);

   always_ff @(posedge clock) begin
      if (load1) begin
         op_ff         <= ipss_pkg::op_type'(req_ch.payload.op);
         seed_ff[0]    <= req_ch.payload.start_x;
         seed_ff[1]    <= req_ch.payload.start_y;
         seed_ff[2]    <= req_ch.payload.start_z;
         press_prod_ff <= press_prod_in;
         temp_prod_ff  <= temp_prod_in;
      end
   end

   // Axis lanes.
   logic signed [ipss_pkg::GYRO_W-1:0] gyro_s[3];
   ipss_pkg::accel_type                accel_s[3];
   logic signed [15:0]                 gyro_raw[3];
   logic signed [15:0]                 accel_raw[3];

   assign gyro_raw[0]  = req_ch.payload.gyro_raw_x;
   assign gyro_raw[1]  = req_ch.payload.gyro_raw_y;
   assign gyro_raw[2]  = req_ch.payload.gyro_raw_z;
   assign accel_raw[0] = req_ch.payload.accel_raw_x;
   assign accel_raw[1] = req_ch.payload.accel_raw_y;
   assign accel_raw[2] = req_ch.payload.accel_raw_z;

   for (genvar g = 0; g < 3; g++) begin : g_axis
      ipss_lane #(.OUT_W(ipss_pkg::GYRO_W)) u_gyro (
         .clock  (clock),
         .load   (load1),
         .raw    (gyro_raw[g]),
         .gain   (gyro_gain_ff),
         .scaled (gyro_s[g])
      );
      ipss_lane #(.OUT_W(ipss_pkg::ACCEL_W)) u_accel (
         .clock  (clock),
         .load   (load1),
         .raw    (accel_raw[g]),
         .gain   (accel_gain_ff),
         .scaled (accel_s[g])
      );
   end

   // Merge of the accelerometer lanes into the capture state.
   ipss_pkg::track_ctrl_type track_ctrl;
   ipss_pkg::span_type       span_next[3];
   logic                     cap_next;

   assign track_ctrl.fire = fire;
   assign track_ctrl.op   = op_ff;

   ipss_track u_track (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (track_ctrl),
      .acc       (accel_s),
      .seed      (seed_ff),
      .span_next (span_next),
      .cap_next  (cap_next)
   );

   // Output register.
   ipss_pkg::rsp_type rsp_ff;
   ipss_pkg::rsp_type rsp_in;

   always_comb begin
      rsp_in.pressure_tenths   = press_prod_ff[ipss_pkg::PRESS_SHIFT +: 15];
      rsp_in.temperature_tenth = temp_prod_ff[ipss_pkg::TEMP_SHIFT +: 13];
      rsp_in.gyro_x            = gyro_s[0];
      rsp_in.gyro_y            = gyro_s[1];
      rsp_in.gyro_z            = gyro_s[2];
      rsp_in.accel_x           = accel_s[0];
      rsp_in.accel_y           = accel_s[1];
      rsp_in.accel_z           = accel_s[2];
      rsp_in.peak_to_peak_x    = span_next[0];
      rsp_in.peak_to_peak_y    = span_next[1];
      rsp_in.peak_to_peak_z    = span_next[2];
      rsp_in.capturing         = cap_next;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.payload = rsp_ff;

   // A start word leaves with capture on and all spans cleared.
   assert property (@(posedge clock) disable iff (reset)
      fire && op_ff == ipss_pkg::OP_START |=> rsp_ch.valid && rsp_ch.payload.capturing
         && rsp_ch.payload.peak_to_peak_x == '0 && rsp_ch.payload.peak_to_peak_y == '0
         && rsp_ch.payload.peak_to_peak_z == '0)
      else $error("start word did not open a fresh capture");

   // A stop word leaves with capture off.
   assert property (@(posedge clock) disable iff (reset)
      fire && op_ff == ipss_pkg::OP_STOP |=> rsp_ch.valid && !rsp_ch.payload.capturing)
      else $error("stop word left capture on");

   // The input side only stalls when both stages hold a word and the output waits.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled with room in the pipeline");

endmodule
